// ----- design/tlvp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tlvp_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [7:0] LEN_EXT16 = 8'hFE;
  localparam logic [7:0] LEN_EXT32 = 8'hFF;
  localparam int TAG_CONS_BIT = 6;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_HDR  = 2'd1;
  localparam logic [1:0] EV_VAL  = 2'd2;
  localparam logic [1:0] EV_ERR  = 2'd3;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_OVERRUN = 3'd1;
  localparam logic [2:0] ERR_EMPTY   = 3'd2;
  localparam logic [2:0] ERR_TRUNC   = 3'd3;
  localparam logic [2:0] ERR_DEEP    = 3'd4;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  tag_value;
    logic        is_constructed;
    logic [31:0] element_length;
    logic [3:0]  nest_depth;
    logic [7:0]  value_out;
    logic        value_end;
    logic [2:0]  error_kind;
    logic        message_done;
    logic        message_ok;
  } res_t;

  typedef struct packed {
    logic             idle;
    logic [LVL_W-1:0] level;
  } core_status_t;

endpackage
`default_nettype wire

// ----- design/tlvp_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tlvp_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   final_byte,
  output tlvp_pkg::res_t         res,
  output tlvp_pkg::core_status_t status
);
  import tlvp_pkg::*;

  typedef enum logic [4:0] {
    PH_TAG = 5'b00001,
    PH_LEN = 5'b00010,
    PH_EXT = 5'b00100,
    PH_VAL = 5'b01000,
    PH_ERR = 5'b10000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [31:0]      off_r, off_nxt;
  logic [7:0]       tag_r, tag_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [2:0]       ext_r, ext_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [2:0]       err_r, err_nxt;
  logic [32:0]      stack_r [MAX_DEPTH];

  logic             have_parent;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] push_idx;
  logic [32:0]      top_end;
  logic [32:0]      off_ext;
  logic [32:0]      next_off;
  logic [31:0]      acc_shift;
  logic [2:0]       ext_dec;
  logic [31:0]      len_sel;
  logic [32:0]      hdr_end;
  logic [31:0]      rem_dec;
  logic             cons;
  logic             hdr_fire;
  logic             push_en;
  logic [2:0]       err;
  logic [LVL_W-1:0] pop_level;

  assign have_parent = (level_r != '0);
  assign top_idx     = IDX_W'(level_r - LVL_W'(1));
  assign push_idx    = IDX_W'(level_r);
  assign top_end     = stack_r[top_idx];
  assign off_ext     = {1'b0, off_r};
  assign next_off    = off_ext + 33'd1;
  assign acc_shift   = {acc_r[23:0], data_byte};
  assign ext_dec     = (ext_r != 3'd0) ? ext_r - 3'd1 : 3'd0;
  assign len_sel     = (phase_r == PH_LEN) ? {24'd0, data_byte} : acc_shift;
  assign hdr_end     = next_off + {1'b0, len_sel};
  assign rem_dec     = (rem_r != 32'd0) ? rem_r - 32'd1 : 32'd0;
  assign cons        = tag_r[TAG_CONS_BIT];

  // ends are nested, so the levels that survive are those still open past next_off
  always_comb begin
    pop_level = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((LVL_W'(i) < level_r) && (stack_r[i] > next_off)) begin
        pop_level = pop_level + LVL_W'(1);
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r + 32'd1;
    tag_nxt   = tag_r;
    acc_nxt   = acc_r;
    ext_nxt   = ext_r;
    rem_nxt   = rem_r;
    level_nxt = level_r;
    err_nxt   = err_r;
    res       = '0;
    err       = ERR_NONE;
    hdr_fire  = 1'b0;
    push_en   = 1'b0;

    case (phase_r)
      PH_TAG: begin
        tag_nxt   = data_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN, PH_EXT: begin
        if (have_parent && (off_ext >= top_end)) begin
          err = ERR_OVERRUN;
        end else if ((phase_r == PH_LEN) &&
                     ((data_byte == LEN_EXT16) || (data_byte == LEN_EXT32))) begin
          ext_nxt   = (data_byte == LEN_EXT16) ? 3'd2 : 3'd4;
          acc_nxt   = 32'd0;
          phase_nxt = PH_EXT;
        end else begin
          if (phase_r == PH_EXT) begin
            acc_nxt = acc_shift;
            ext_nxt = ext_dec;
          end
          hdr_fire = (phase_r == PH_LEN) || (ext_dec == 3'd0);
        end
      end
      PH_VAL: begin
        res.event_kind = EV_VAL;
        res.value_out  = data_byte;
        res.value_end  = (rem_r <= 32'd1);
        rem_nxt        = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_nxt = PH_TAG;
          level_nxt = pop_level;
        end
      end
      PH_ERR: begin
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase

    if (hdr_fire) begin
      if (have_parent && (hdr_end > top_end)) begin
        err = ERR_OVERRUN;
      end else if (cons && (len_sel == 32'd0)) begin
        err = ERR_EMPTY;
      end else if (cons && (level_r >= LVL_W'(MAX_DEPTH))) begin
        err = ERR_DEEP;
      end else begin
        res.event_kind     = EV_HDR;
        res.tag_value      = tag_r;
        res.is_constructed = cons;
        res.element_length = len_sel;
        res.nest_depth     = 4'(level_r);
        if (cons) begin
          push_en   = 1'b1;
          level_nxt = level_r + LVL_W'(1);
          phase_nxt = PH_TAG;
        end else if (len_sel != 32'd0) begin
          rem_nxt   = len_sel;
          phase_nxt = PH_VAL;
        end else begin
          phase_nxt = PH_TAG;
          level_nxt = pop_level;
        end
      end
    end

    if (err != ERR_NONE) begin
      res            = '0;
      res.event_kind = EV_ERR;
      res.error_kind = err;
      err_nxt        = err;
      phase_nxt      = PH_ERR;
    end

    if (final_byte) begin
      // message ends inside an element
      if ((phase_nxt != PH_ERR) && ((phase_nxt != PH_TAG) || (level_nxt != '0))) begin
        res            = '0;
        res.event_kind = EV_ERR;
        err_nxt        = ERR_TRUNC;
      end
      res.error_kind   = err_nxt;
      res.message_done = 1'b1;
      res.message_ok   = (err_nxt == ERR_NONE);
      phase_nxt = PH_TAG;
      off_nxt   = 32'd0;
      tag_nxt   = 8'd0;
      acc_nxt   = 32'd0;
      ext_nxt   = 3'd0;
      rem_nxt   = 32'd0;
      level_nxt = '0;
      err_nxt   = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      off_r   <= 32'd0;
      tag_r   <= 8'd0;
      acc_r   <= 32'd0;
      ext_r   <= 3'd0;
      rem_r   <= 32'd0;
      level_r <= '0;
      err_r   <= ERR_NONE;
    end else if (step) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      tag_r   <= tag_nxt;
      acc_r   <= acc_nxt;
      ext_r   <= ext_nxt;
      rem_r   <= rem_nxt;
      level_r <= level_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && push_en) begin
      stack_r[push_idx] <= hdr_end;
    end
  end

  assign status.idle  = (phase_r == PH_TAG) && (level_r == '0);
  assign status.level = level_r;

endmodule
`default_nettype wire

// ----- design/nested_tlv_stream_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// an accepted word is held in the input register, parsed, then written to the result queue
// throughput: one word per cycle while in_stall is low; the parse step, with its end-offset
// compare bank, is combinational between the input register and a two-entry result queue
// reset: rst_n clears parser state and the queue; the end-offset stack is not
// cleared, only levels that were pushed are read
module nested_tlv_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_tag_value,
  output logic        out_is_constructed,
  output logic [31:0] out_element_length,
  output logic [3:0]  out_nest_depth,
  output logic [7:0]  out_value_out,
  output logic        out_value_end,
  output logic [2:0]  out_error_kind,
  output logic        out_message_done,
  output logic        out_message_ok
);
  import tlvp_pkg::*;

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_fin_r;
  logic [1:0]   cnt_r;
  res_t         slot0_r;
  res_t         slot1_r;
  res_t         core_res;
  core_status_t core_st;
  logic         accept;
  logic         pop;
  logic [2:0]   fill_after;

  assign pop        = (cnt_r != 2'd0) && !out_stall;
  assign fill_after = {1'b0, cnt_r} + {2'b00, s1_valid_r} - {2'b00, pop};
  assign in_stall   = (fill_after >= 3'd2);
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_data_byte;
      s1_fin_r  <= in_final_byte;
    end
  end

  tlvp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_valid_r),
    .data_byte  (s1_byte_r),
    .final_byte (s1_fin_r),
    .res        (core_res),
    .status     (core_st)
  );

  // result queue: slot0 drives the ports, slot1 is the skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, s1_valid_r} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        slot0_r <= slot1_r;
        if (s1_valid_r) begin
          slot1_r <= core_res;
        end
      end else if (s1_valid_r) begin
        slot0_r <= core_res;
      end
    end else if (s1_valid_r) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= core_res;
      end else begin
        slot1_r <= core_res;
      end
    end
  end

  assign out_valid          = (cnt_r != 2'd0);
  assign out_event_kind     = slot0_r.event_kind;
  assign out_tag_value      = slot0_r.tag_value;
  assign out_is_constructed = slot0_r.is_constructed;
  assign out_element_length = slot0_r.element_length;
  assign out_nest_depth     = slot0_r.nest_depth;
  assign out_value_out      = slot0_r.value_out;
  assign out_value_end      = slot0_r.value_end;
  assign out_error_kind     = slot0_r.error_kind;
  assign out_message_done   = slot0_r.message_done;
  assign out_message_ok     = slot0_r.message_ok;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((cnt_r != 2'd2) || pop))
    else $error("result queue overflow");

  a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == 2'd0) && !s1_valid_r) |-> !in_stall)
    else $error("stall with empty pipeline");

  a_msg_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_fin_r) |=> core_st.idle)
    else $error("parser not idle after final word");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (core_st.level <= LVL_W'(MAX_DEPTH)))
    else $error("nesting level beyond stack depth");

endmodule
`default_nettype wire
